[rtl/hrs_pkg.sv]
// Shared types, codes and constants of the heat-up run segmenter.
package hrs_pkg;

    // Default depth of the inlet temperature ring.
    localparam int RING_DEPTH_DEF = 256;

    // Values that stand in for a register that holds zero.
    localparam logic [9:0] DEFAULT_WINDOW = 10'd90;
    localparam logic [7:0] DEFAULT_DROP   = 8'd5;
    localparam logic [7:0] DEFAULT_GAP    = 8'd5;

    // Tenths of a degree per whole degree.
    localparam logic [3:0] TENTHS = 4'd10;

    // Saturation value of the run duration counter.
    localparam logic [23:0] DUR_MAX = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        CAUSE_MASTER_OFF = 2'd0,
        CAUSE_FAULT      = 2'd1,
        CAUSE_DRAW       = 2'd2,
        CAUSE_TARGET     = 2'd3
    } t_cause;

    typedef enum logic [1:0] {
        REG_DRAW_WINDOW = 2'd0,
        REG_DRAW_DROP   = 2'd1,
        REG_MIN_GAP     = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic              heating;
        logic [7:0]        mode;
        logic [7:0]        target_temp;
        logic signed [11:0] water_temp;
        logic              water_valid;
        logic signed [11:0] inlet_temp;
        logic              inlet_valid;
        logic              master_on;
        logic              safety_fault;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         event_res;
        logic [1:0]         end_cause;
        logic [7:0]         run_mode;
        logic [7:0]         run_target;
        logic signed [11:0] start_temp;
        logic signed [11:0] end_temp;
        logic [23:0]        duration;
        logic               draw_seen;
    } t_out_item;

    typedef struct packed {
        logic [1:0] reg_idx;
        logic [9:0] wdata;
    } t_cfg_req;

endpackage

[rtl/hrs_if.sv]
// Valid/ready channel interfaces for the input, result and configuration requests.
interface hrs_in_if;
    import hrs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hrs_out_if;
    import hrs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hrs_cfg_if;
    import hrs_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/heatup_run_segmenter_core.sv]
// Heat-up run segmenter: inlet draw detection over a ring memory and run tracking.
//
// Each request on i_in is one one-second tick and yields exactly one result request
// on o_out, carrying a run start, a run end or no event, plus the draw flag. The
// block takes one request per clock cycle sustained while o_out does not stall. A
// result reaches the output register from the second stage, which holds its tick
// while o_out stalls. The rate is set by the inlet ring memory, which has one write
// port and one read port with a registered read: a tick reads the sample one
// look-back window ago in the first stage, then compares, writes its own sample and
// updates the run state in the second stage. When the window is one tick, the
// sample written by the previous tick is forwarded. The ring needs no clearing pass
// after reset, because an entry is only read after it has been written since the
// last fill restart. Requests on i_in and i_cfg are refused while reset is held.
// Configuration writes on i_cfg are otherwise always taken and must only be made
// while the block holds no unfinished request.
module heatup_run_segmenter_core #(
    parameter int RING_DEPTH = hrs_pkg::RING_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hrs_in_if.sink          i_in,
    hrs_out_if.source       o_out,
    hrs_cfg_if.sink         i_cfg
);
    import hrs_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int HW = $clog2(RING_DEPTH + 1);
    localparam int CW = (AW > 10) ? AW + 1 : 11;

    // Configuration registers.
    logic [9:0] r_draw_window;
    logic [7:0] r_draw_drop;
    logic [7:0] r_min_gap;

    // Ring memory and its fill tracking. The pointer and fill count only depend on
    // inlet validity, so they are kept at the front of the pipeline.
    logic [11:0]   r_ring [RING_DEPTH];
    logic [AW-1:0] r_wp;
    logic [HW-1:0] r_held;
    logic [11:0]   r_rdata;
    logic          r_fwd;
    logic [11:0]   r_fwd_data;

    // Second stage: the tick waiting for its ring sample.
    logic          r_s1_valid;
    t_in_item      r_s1_item;
    logic          r_s1_chk;
    logic [AW-1:0] r_s1_wp;

    // Run state.
    logic        r_run_active;
    logic [9:0]  r_rearm;
    logic [7:0]  r_saved_mode;
    logic [7:0]  r_saved_target;
    logic [11:0] r_saved_start;
    logic [23:0] r_run_ticks;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    logic          in_fire;
    logic          s1_adv;
    logic [9:0]    win_full;
    logic [CW-1:0] win_c;
    logic [AW-1:0] win_a;
    logic [AW:0]   rd_sum;
    logic [AW-1:0] rd_addr;
    logic          chk;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] n_wp;
    logic [HW-1:0] n_held;

    logic [11:0]        old_sample;
    logic signed [12:0] inlet_diff;
    logic signed [12:0] drop_lim;
    logic               draw_hit;
    logic signed [13:0] gap_lim;
    logic signed [13:0] water_ext;
    logic               big_gap;
    logic [7:0]         drop_eff;
    logic [7:0]         gap_eff;
    logic [11:0]        water_or_zero;

    logic        n_run_active;
    logic [9:0]  n_rearm;
    logic [7:0]  n_saved_mode;
    logic [7:0]  n_saved_target;
    logic [11:0] n_saved_start;
    logic [23:0] n_run_ticks;
    t_out_item   n_out;

    // Handshakes. The output register frees the second stage when empty or when the
    // result side takes it, so a new tick can enter every cycle unless o_out stalls.
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = i_rst_n && (!r_s1_valid || s1_adv);
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = i_rst_n;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    // First stage: look-back address and fill bookkeeping.
    always_comb begin
        win_full = (r_draw_window != 10'd0) ? r_draw_window : DEFAULT_WINDOW;
        if (CW'(win_full) > CW'(RING_DEPTH - 1)) begin
            win_c = CW'(RING_DEPTH - 1);
        end else begin
            win_c = CW'(win_full);
        end
        win_a = win_c[AW-1:0];
        if (r_wp >= win_a) begin
            rd_sum = {1'b0, r_wp} - {1'b0, win_a};
        end else begin
            rd_sum = {1'b0, r_wp} + (AW+1)'(RING_DEPTH) - {1'b0, win_a};
        end
        rd_addr = rd_sum[AW-1:0];
        chk     = i_in.payload.inlet_valid && (CW'(r_held) >= win_c);
        rd_en   = in_fire && chk;

        if (!i_in.payload.inlet_valid) begin
            n_wp   = '0;
            n_held = '0;
        end else begin
            n_wp   = (r_wp == AW'(RING_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            n_held = (r_held == HW'(RING_DEPTH)) ? r_held : r_held + 1'b1;
        end
    end

    assign wr_en = s1_adv && r_s1_item.inlet_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[r_s1_wp] <= r_s1_item.inlet_temp;
        end
        if (rd_en) begin
            r_rdata    <= r_ring[rd_addr];
            r_fwd      <= wr_en && (r_s1_wp == rd_addr);
            r_fwd_data <= r_s1_item.inlet_temp;
        end
    end

    // Second stage: draw decision and run segmentation.
    always_comb begin
        old_sample = r_fwd ? r_fwd_data : r_rdata;
        inlet_diff = $signed({old_sample[11], old_sample})
                   - $signed({r_s1_item.inlet_temp[11], r_s1_item.inlet_temp});
        drop_eff   = (r_draw_drop != 8'd0) ? r_draw_drop : DEFAULT_DROP;
        drop_lim   = $signed({1'b0, 12'({4'b0, drop_eff} * {8'b0, TENTHS})});
        draw_hit   = r_s1_chk && (inlet_diff >= drop_lim);

        gap_eff   = (r_min_gap != 8'd0) ? r_min_gap : DEFAULT_GAP;
        gap_lim   = ($signed({6'b0, r_s1_item.target_temp}) - $signed({6'b0, gap_eff}))
                  * $signed({10'b0, TENTHS});
        water_ext = $signed({{2{r_s1_item.water_temp[11]}}, r_s1_item.water_temp});
        big_gap   = r_s1_item.water_valid && (water_ext <= gap_lim);
        water_or_zero = r_s1_item.water_valid ? r_s1_item.water_temp : 12'd0;

        n_run_active   = r_run_active;
        n_rearm        = r_rearm;
        n_saved_mode   = r_saved_mode;
        n_saved_target = r_saved_target;
        n_saved_start  = r_saved_start;
        n_run_ticks    = r_run_ticks;
        n_out          = '0;

        // A tick that begins with a run active adds to its duration.
        if (r_run_active && (r_run_ticks != DUR_MAX)) begin
            n_run_ticks = r_run_ticks + 1'b1;
        end
        n_out.draw_seen = draw_hit;

        if (!r_s1_item.master_on || r_s1_item.safety_fault) begin
            // Master off or a fault closes any run and cancels re-arming.
            if (r_run_active) begin
                n_out.event_res = EV_END;
                n_out.end_cause = r_s1_item.master_on ? CAUSE_FAULT : CAUSE_MASTER_OFF;
                n_run_active    = 1'b0;
            end
            n_rearm = '0;
        end else begin
            if (draw_hit) begin
                if (r_run_active) begin
                    n_out.event_res = EV_END;
                    n_out.end_cause = CAUSE_DRAW;
                    n_run_active    = 1'b0;
                end
                n_rearm = win_full;
            end else if (r_rearm != 10'd0) begin
                n_rearm = r_rearm - 1'b1;
            end

            if (r_s1_item.heating) begin
                if (!n_run_active && !draw_hit) begin
                    // Start on a large gap to target or inside the re-arm window.
                    if (big_gap || (n_rearm != 10'd0)) begin
                        n_run_active     = 1'b1;
                        n_saved_mode     = r_s1_item.mode;
                        n_saved_target   = r_s1_item.target_temp;
                        n_saved_start    = water_or_zero;
                        n_run_ticks      = '0;
                        n_rearm          = '0;
                        n_out.event_res  = EV_START;
                        n_out.run_mode   = r_s1_item.mode;
                        n_out.run_target = r_s1_item.target_temp;
                        n_out.start_temp = water_or_zero;
                    end
                end else if (n_run_active) begin
                    // While heating goes on, the run follows mode and target.
                    n_saved_mode   = r_s1_item.mode;
                    n_saved_target = r_s1_item.target_temp;
                end
            end else if (n_run_active) begin
                // Heating stopped: the target was reached.
                n_out.event_res = EV_END;
                n_out.end_cause = CAUSE_TARGET;
                n_run_active    = 1'b0;
            end
        end

        if (n_out.event_res == EV_END) begin
            n_out.run_mode   = r_saved_mode;
            n_out.run_target = r_saved_target;
            n_out.start_temp = r_saved_start;
            n_out.end_temp   = water_or_zero;
            n_out.duration   = n_run_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_window  <= '0;
            r_draw_drop    <= '0;
            r_min_gap      <= '0;
            r_wp           <= '0;
            r_held         <= '0;
            r_s1_valid     <= 1'b0;
            r_run_active   <= 1'b0;
            r_rearm        <= '0;
            r_saved_mode   <= '0;
            r_saved_target <= '0;
            r_saved_start  <= '0;
            r_run_ticks    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (t_reg_idx'(i_cfg.payload.reg_idx))
                    REG_DRAW_WINDOW: r_draw_window <= i_cfg.payload.wdata;
                    REG_DRAW_DROP:   r_draw_drop   <= i_cfg.payload.wdata[7:0];
                    REG_MIN_GAP:     r_min_gap     <= i_cfg.payload.wdata[7:0];
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                r_wp   <= n_wp;
                r_held <= n_held;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_run_active   <= n_run_active;
                r_rearm        <= n_rearm;
                r_saved_mode   <= n_saved_mode;
                r_saved_target <= n_saved_target;
                r_saved_start  <= n_saved_start;
                r_run_ticks    <= n_run_ticks;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in.payload;
            r_s1_chk  <= chk;
            r_s1_wp   <= r_wp;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    // Forwarding is only needed when the look-back is a single tick.
    a_fwd_window_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_fwd) |-> $past(win_a == AW'(1)))
        else $error("ring forwarding with a look-back other than one");

    // A run that begins is reported as a start and counts from zero.
    a_start_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_run_active) |-> (r_out_valid && (r_out.event_res == EV_START)
                                 && (r_run_ticks == 24'd0)))
        else $error("run started without a start result");

    // A run that stops is reported as an end.
    a_end_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_run_active) |-> (r_out_valid && (r_out.event_res == EV_END)))
        else $error("run ended without an end result");

    // Fill tracking stays inside the ring.
    a_fill_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp <= AW'(RING_DEPTH - 1)) && (r_held <= HW'(RING_DEPTH)))
        else $error("ring pointer or fill count out of range");

endmodule

[verif/heatup_run_segmenter_core_test.sv]
// Self-checking testbench of the heat-up run segmenter core with a built-in tick predictor.
module heatup_run_segmenter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hrs_pkg::*;

    localparam int RING_N = RING_DEPTH_DEF;

    logic i_clk;
    logic i_rst_n;

    hrs_in_if  in_bus ();
    hrs_out_if out_bus ();
    hrs_cfg_if cfg_bus ();

    heatup_run_segmenter_core #(
        .RING_DEPTH (RING_N)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .i_cfg   (cfg_bus)
    );

    // Ticks waiting to be offered to the block, and the results predicted for the
    // ticks that it has already taken, oldest first.
    t_in_item  pending_ticks[$];
    t_out_item predicted_events[$];

    // Idling of both sides in percent of cycles, changed only between phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Set at a rising edge when the block took the tick on offer, so that the
    // driver knows at the falling edge whether to move on to the next one.
    bit in_taken = 1'b0;

    int err_cnt    = 0;
    int result_cnt = 0;

    // Predictor state: the inlet ring, the draw and re-arm tracking, the open run
    // and our own copy of the three registers.
    logic signed [11:0] inlet_ring [RING_N];
    int          ring_wr     = 0;
    int          ring_fill   = 0;
    bit          draw_active = 1'b0;
    int          rearm_left  = 0;
    bit          run_on      = 1'b0;
    logic [7:0]  run_mode_q  = '0;
    logic [7:0]  run_target_q = '0;
    logic signed [11:0] run_start_q = '0;
    logic [23:0] run_len     = '0;
    logic [9:0]  cfg_window  = '0;
    logic [7:0]  cfg_drop    = '0;
    logic [7:0]  cfg_gap     = '0;

    t_out_item mon_want;
    t_out_item mon_got;
    string     mon_bad;

    // Clock of the bench.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Closes the open run and builds its end event.
    function automatic t_out_item run_close(t_cause cause, logic signed [11:0] wt, bit wv,
                                            bit draw);
        t_out_item r;
        r = '0;
        r.event_res  = EV_END;
        r.end_cause  = cause;
        r.run_mode   = run_mode_q;
        r.run_target = run_target_q;
        r.start_temp = run_start_q;
        r.end_temp   = wv ? wt : 12'sd0;
        r.duration   = run_len;
        r.draw_seen  = draw;
        run_on = 1'b0;
        return r;
    endfunction

    // Advances the predictor by one tick and returns the result that the tick yields.
    function automatic t_out_item segment_tick(t_in_item t);
        t_out_item r;
        int span;
        int look;
        int drop_tenths;
        int gap_deg;
        int past_c;
        int now_c;
        int water_c;
        int tgt_c;
        bit draw;
        bit big_gap;
        r = '0;
        draw = 1'b0;
        // The window sets the re-arm length as written, but the look-back is
        // limited by what the ring can hold.
        span = (cfg_window != 0) ? int'(cfg_window) : int'(DEFAULT_WINDOW);
        look = (span > RING_N - 1) ? RING_N - 1 : span;
        if (run_on && run_len != DUR_MAX) run_len = run_len + 24'd1;

        if (!t.inlet_valid) begin
            // Sensor loss restarts the fill; old ring contents are never read again.
            ring_wr   = 0;
            ring_fill = 0;
        end else begin
            drop_tenths = ((cfg_drop != 0) ? int'(cfg_drop) : int'(DEFAULT_DROP))
                          * int'(TENTHS);
            now_c = $signed(t.inlet_temp);
            if (ring_fill >= look) begin
                past_c = inlet_ring[(ring_wr + RING_N - look) % RING_N];
                draw = (past_c - now_c >= drop_tenths);
            end
            inlet_ring[ring_wr] = t.inlet_temp;
            ring_wr = (ring_wr + 1) % RING_N;
            if (ring_fill < RING_N) ring_fill++;
        end
        r.draw_seen = draw;

        // Master off or a fault ends any run and drops the re-arm window, but the
        // draw flag is still reported.
        if (!t.master_on || t.safety_fault) begin
            if (run_on) r = run_close(t.master_on ? CAUSE_FAULT : CAUSE_MASTER_OFF,
                                      t.water_temp, t.water_valid, draw);
            draw_active = 1'b0;
            rearm_left  = 0;
            return r;
        end

        if (draw) begin
            if (run_on) r = run_close(CAUSE_DRAW, t.water_temp, t.water_valid, draw);
            draw_active = 1'b1;
            rearm_left  = span;
        end else begin
            draw_active = 1'b0;
            if (rearm_left > 0) rearm_left--;
        end

        if (t.heating) begin
            if (!run_on && !draw_active) begin
                gap_deg = (cfg_gap != 0) ? int'(cfg_gap) : int'(DEFAULT_GAP);
                water_c = $signed(t.water_temp);
                tgt_c   = int'(t.target_temp);
                big_gap = t.water_valid && (water_c <= (tgt_c - gap_deg) * int'(TENTHS));
                if (big_gap || rearm_left > 0) begin
                    run_on       = 1'b1;
                    run_mode_q   = t.mode;
                    run_target_q = t.target_temp;
                    run_start_q  = t.water_valid ? t.water_temp : 12'sd0;
                    run_len      = '0;
                    rearm_left   = 0;
                    r.event_res  = EV_START;
                    r.run_mode   = t.mode;
                    r.run_target = t.target_temp;
                    r.start_temp = run_start_q;
                end
            end else if (run_on) begin
                // A run in progress follows the live mode and target.
                run_mode_q   = t.mode;
                run_target_q = t.target_temp;
            end
        end else if (run_on) begin
            // Heating stopped, so the heater reached its target.
            r = run_close(CAUSE_TARGET, t.water_temp, t.water_valid, draw);
        end
        return r;
    endfunction

    function automatic string show(t_out_item r);
        return $sformatf("ev=%0d cause=%0d mode=%0d tgt=%0d start=%0d end=%0d dur=%0d draw=%0d",
                         r.event_res, r.end_cause, r.run_mode, r.run_target,
                         $signed(r.start_temp), $signed(r.end_temp), r.duration, r.draw_seen);
    endfunction

    task automatic flag_error(string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic logic signed [11:0] sat12(int v);
        if (v > 2047) return 12'h7FF;
        if (v < -2048) return 12'h800;
        return v[11:0];
    endfunction

    // Driver: every request is presented at a falling edge and held until taken.
    always @(negedge i_clk) begin
        out_bus.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_taken) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_bus.valid   <= 1'b1;
                in_bus.payload <= pending_ticks.pop_front();
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts each accepted tick and checks each accepted result
    // against the oldest prediction, field by field.
    always @(posedge i_clk) begin
        in_taken <= in_bus.valid && in_bus.ready;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready)
                predicted_events.push_back(segment_tick(in_bus.payload));
            if (out_bus.valid && out_bus.ready) begin
                mon_got = out_bus.payload;
                result_cnt++;
                if (predicted_events.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with none pending: %s",
                                         result_cnt, show(mon_got)));
                end else begin
                    mon_want = predicted_events.pop_front();
                    mon_bad  = "";
                    if (mon_got.event_res !== mon_want.event_res) mon_bad = {mon_bad, " event"};
                    if (mon_got.end_cause !== mon_want.end_cause) mon_bad = {mon_bad, " cause"};
                    if (mon_got.run_mode !== mon_want.run_mode) mon_bad = {mon_bad, " mode"};
                    if (mon_got.run_target !== mon_want.run_target) mon_bad = {mon_bad, " target"};
                    if (mon_got.start_temp !== mon_want.start_temp) mon_bad = {mon_bad, " start"};
                    if (mon_got.end_temp !== mon_want.end_temp) mon_bad = {mon_bad, " end"};
                    if (mon_got.duration !== mon_want.duration) mon_bad = {mon_bad, " duration"};
                    if (mon_got.draw_seen !== mon_want.draw_seen) mon_bad = {mon_bad, " draw"};
                    if (mon_bad != "")
                        flag_error($sformatf("result %0d differs in%s: expected %s, got %s",
                                             result_cnt, mon_bad, show(mon_want),
                                             show(mon_got)));
                end
            end
        end
    end

    // A register write is a request on the configuration channel; our copy of the
    // register changes at the edge that takes it.
    task automatic write_reg(t_reg_idx idx, logic [9:0] val);
        t_cfg_req req;
        req.reg_idx = idx;
        req.wdata   = val;
        @(negedge i_clk);
        cfg_bus.valid   <= 1'b1;
        cfg_bus.payload <= req;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        case (idx)
            REG_DRAW_WINDOW: cfg_window = val;
            REG_DRAW_DROP:   cfg_drop   = val[7:0];
            REG_MIN_GAP:     cfg_gap    = val[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Waits until every tick is taken and every predicted result has come back,
    // then lets the pipeline settle.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_ticks.size() != 0 || in_bus.valid || predicted_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic push_tick(bit heat, logic [7:0] md, logic [7:0] tg, int wt, bit wv,
                             int it, bit iv, bit mon, bit flt);
        t_in_item t;
        t.heating      = heat;
        t.mode         = md;
        t.target_temp  = tg;
        t.water_temp   = wt[11:0];
        t.water_valid  = wv;
        t.inlet_temp   = it[11:0];
        t.inlet_valid  = iv;
        t.master_on    = mon;
        t.safety_fault = flt;
        pending_ticks.push_back(t);
    endtask

    // Random ticks shaped like real heater traffic: heating bursts, a water
    // temperature mostly at or below the target, a steady inlet with occasional dips deep
    // enough to flag a draw, and a little noise of sensor loss, faults and
    // master off.
    task automatic gen_ticks(int count);
        t_in_item t;
        int base_c;
        int heat_left;
        int dip_left;
        int thr;
        int water_c;
        int inlet_c;
        int tgt;
        bit heat_on;
        base_c    = int'($urandom_range(200, 800));
        tgt       = int'($urandom_range(20, 90));
        heat_on   = 1'b0;
        heat_left = 0;
        dip_left  = 0;
        thr = ((cfg_drop != 0) ? int'(cfg_drop) : int'(DEFAULT_DROP)) * int'(TENTHS);
        repeat (count) begin
            if (heat_left == 0) begin
                heat_on   = !heat_on;
                heat_left = int'($urandom_range(1, 40));
            end
            heat_left--;
            if ($urandom_range(99) < 3) tgt = int'($urandom_range(0, 255));
            if ($urandom_range(99) < 10) base_c = base_c + int'($urandom_range(0, 40)) - 20;

            if ($urandom_range(9) < 2) water_c = int'($urandom_range(0, 4095)) - 2048;
            else water_c = tgt * 10 - int'($urandom_range(0, 300));

            if (dip_left == 0 && $urandom_range(99) < 4) dip_left = int'($urandom_range(1, 4));
            if (dip_left != 0) begin
                inlet_c = base_c - thr - int'($urandom_range(0, 100));
                dip_left--;
            end else if ($urandom_range(99) < 3) begin
                inlet_c = int'($urandom_range(0, 4095)) - 2048;
            end else begin
                inlet_c = base_c + int'($urandom_range(0, 6)) - 3;
            end

            t.heating      = heat_on;
            t.mode         = 8'($urandom);
            t.target_temp  = tgt[7:0];
            t.water_temp   = sat12(water_c);
            t.water_valid  = ($urandom_range(19) != 0);
            t.inlet_temp   = sat12(inlet_c);
            t.inlet_valid  = ($urandom_range(199) != 0);
            t.master_on    = ($urandom_range(99) >= 4);
            t.safety_fault = ($urandom_range(99) < 3);
            pending_ticks.push_back(t);
        end
    endtask

    // One phase: a register setting and an idling pattern. Halfway through, the
    // sender holds back until every result so far has come in.
    task automatic run_phase(logic [9:0] win, logic [9:0] drop, logic [9:0] gap, int count,
                             int send_pct, int stall_pct);
        write_reg(REG_DRAW_WINDOW, win);
        write_reg(REG_DRAW_DROP, drop);
        write_reg(REG_MIN_GAP, gap);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        gen_ticks(count / 2);
        wait_drained();
        gen_ticks(count - count / 2);
        wait_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_bus.valid    = 1'b0;
        in_bus.payload  = '0;
        out_bus.ready   = 1'b0;
        cfg_bus.valid   = 1'b0;
        cfg_bus.payload = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The unused index must be ignored; a two-tick window keeps the directed
        // sequence short while drop and gap stay at their defaults.
        write_reg(REG_UNUSED, 10'h3FF);
        write_reg(REG_DRAW_WINDOW, 10'd2);

        // Master off with every field at an extreme, then a fault with master on.
        push_tick(1, 8'hFF, 8'hFF, -2048, 1, 2047, 1, 0, 0);
        push_tick(1, 8'h00, 8'h00, 2047, 1, 2047, 1, 1, 1);
        // A large gap starts a run; mode and target then follow the inputs, and
        // the end of heating closes it as target reached.
        push_tick(1, 8'h5A, 8'd60, 300, 1, 2047, 1, 1, 0);
        push_tick(1, 8'hA5, 8'd61, 400, 1, 2047, 1, 1, 0);
        push_tick(0, 8'h03, 8'd61, 610, 1, 2047, 1, 1, 0);
        // An invalid water reading never counts as a large gap.
        push_tick(1, 8'h07, 8'd255, -2048, 0, 2047, 1, 1, 0);
        // Runs closed by master off and by a fault.
        push_tick(1, 8'h07, 8'd255, -2048, 1, 2047, 1, 1, 0);
        push_tick(1, 8'h07, 8'd255, 100, 1, 2047, 1, 0, 0);
        push_tick(1, 8'h09, 8'd200, 0, 1, 2047, 1, 1, 0);
        push_tick(1, 8'h09, 8'd200, 0, 1, 2047, 1, 1, 1);
        // A run closed by a draw, then a start inside the re-arm window with no
        // gap to speak of, closed with the water reading lost.
        push_tick(1, 8'h04, 8'd100, 500, 1, 2047, 1, 1, 0);
        push_tick(1, 8'h04, 8'd100, 520, 1, 0, 1, 1, 0);
        push_tick(0, 8'h04, 8'd100, 990, 1, 0, 1, 1, 0);
        push_tick(1, 8'h06, 8'd100, 1000, 1, 0, 1, 1, 0);
        push_tick(0, 8'h06, 8'd100, 1001, 0, 0, 1, 1, 0);
        // Inlet sensor loss restarts the fill: no draw until the history is
        // long enough again, even against the stale ring contents.
        push_tick(0, 8'h00, 8'd0, 0, 1, -2048, 0, 1, 0);
        push_tick(0, 8'h00, 8'd0, 0, 1, -2048, 1, 1, 0);
        push_tick(0, 8'h00, 8'd0, 0, 1, -2048, 1, 1, 0);
        push_tick(0, 8'h00, 8'd0, 0, 1, -2048, 1, 1, 0);
        // Water exactly at the gap starts a run; one tenth above does not.
        push_tick(1, 8'h01, 8'd100, 950, 1, -2048, 1, 1, 0);
        push_tick(0, 8'h01, 8'd100, 951, 1, -2048, 1, 1, 0);
        push_tick(1, 8'h02, 8'd100, 951, 1, -2048, 1, 1, 0);
        // A draw is still flagged under master off.
        push_tick(0, 8'h00, 8'd0, 0, 0, 2047, 1, 0, 0);
        push_tick(0, 8'h00, 8'd0, 0, 0, 2047, 1, 0, 0);
        push_tick(0, 8'h00, 8'd0, 0, 0, -2048, 1, 0, 0);
        wait_drained();

        // Defaults, the smallest non-zero settings, the largest, settings with
        // unused upper write bits, a random one, the exact ring limit and a
        // re-arm longer than the look-back.
        run_phase(10'd0, 10'd0, 10'd0, 200, 0, 0);
        run_phase(10'd1, 10'd1, 10'd1, 150, 80, 0);
        run_phase(10'd1023, 10'd255, 10'd255, 280, 0, 80);
        run_phase(10'd3, {2'b11, 8'd2}, {2'b10, 8'd10}, 150, 37, 37);
        run_phase(10'($urandom_range(2, 20)), 10'($urandom_range(1, 30)),
                  10'($urandom_range(0, 40)), 150, 0, 0);
        run_phase(10'd255, 10'd0, 10'd3, 260, 80, 0);
        run_phase(10'd600, 10'd8, 10'd1, 185, 0, 80);

        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && predicted_events.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: the slowest correct run is far below this.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
